FILE: rtl/pwl_pkg.sv
// Shared constants, codes and types of the piecewise linear evaluator.
`default_nettype none

package pwl_pkg;

  // Payload widths fixed by the interface.
  localparam int DATA_W   = 32;
  localparam int ENTRY_W  = 4;
  localparam int NPTS_W   = 5;

  // Defaults of the top-level parameters.
  localparam int MAX_POINTS_DEF = 16;
  localparam int FRAC_BITS_DEF  = 16;

  // Configuration port: one register at byte address 0.
  localparam int ADDR_W    = 3;
  localparam int REG_IDX_W = 1;
  localparam logic [REG_IDX_W-1:0] REG_NUM_POINTS = 1'b0;
  localparam logic [NPTS_W-1:0]    NUM_POINTS_RST = 5'd2;

  typedef enum logic {
    CMD_LOAD = 1'b0,
    CMD_EVAL = 1'b1
  } cmd_e;

  // Operands of one evaluation, handed from segment lookup to arithmetic.
  typedef struct packed {
    logic signed [DATA_W-1:0] slope;
    logic signed [DATA_W-1:0] intercept;
    logic signed [DATA_W-1:0] x;
    logic                     found;
  } mac_req_t;

endpackage

`default_nettype wire

FILE: rtl/pwl_mac.sv
// Multiply, round, intercept add and saturation pipeline with output register.
`default_nettype none

module pwl_mac #(
  parameter int FRAC_BITS = pwl_pkg::FRAC_BITS_DEF
) (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire logic                             req_valid_i,
  output logic                                  req_ready_o,
  input  wire pwl_pkg::mac_req_t                req_i,
  output logic                                  out_valid_o,
  input  wire logic                             out_ready_i,
  output logic signed [pwl_pkg::DATA_W-1:0]     y_value_o,
  output logic                                  out_of_range_o
);

  localparam int DW     = pwl_pkg::DATA_W;
  localparam int PROD_W = 2 * DW;
  localparam int SUM_W  = PROD_W + 1;
  localparam logic signed [PROD_W-1:0] HALF = (PROD_W'(1) << FRAC_BITS) >> 1;
  localparam logic signed [SUM_W-1:0] Y_MAX =
    {{(SUM_W-DW+1){1'b0}}, {(DW-1){1'b1}}};
  localparam logic signed [SUM_W-1:0] Y_MIN =
    {{(SUM_W-DW+1){1'b1}}, {(DW-1){1'b0}}};

  logic                     va_q, vb_q, vc_q;
  logic                     rdy_a, rdy_b, rdy_c;
  logic signed [PROD_W-1:0] prod_d, prod_q;
  logic signed [DW-1:0]     ic_a_q, ic_b_q;
  logic                     found_a_q, found_b_q;
  logic signed [PROD_W-1:0] rnd_d, rnd_q;
  logic signed [SUM_W-1:0]  sum_d;
  logic signed [DW-1:0]     y_d, y_q;
  logic                     oor_q;

  // Each stage moves when it is empty or its successor moves.
  assign rdy_c       = !vc_q || out_ready_i;
  assign rdy_b       = !vb_q || rdy_c;
  assign rdy_a       = !va_q || rdy_b;
  assign req_ready_o = rdy_a;

  assign prod_d = $signed(req_i.slope) * $signed(req_i.x);
  assign rnd_d  = (prod_q + HALF) >>> FRAC_BITS;
  assign sum_d  = SUM_W'(rnd_q) + SUM_W'(ic_b_q);

  always_comb begin
    if (!found_b_q) begin
      y_d = '0;
    end else if (sum_d > Y_MAX) begin
      y_d = Y_MAX[DW-1:0];
    end else if (sum_d < Y_MIN) begin
      y_d = Y_MIN[DW-1:0];
    end else begin
      y_d = sum_d[DW-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      va_q <= 1'b0;
      vb_q <= 1'b0;
      vc_q <= 1'b0;
    end else begin
      if (rdy_a) va_q <= req_valid_i;
      if (rdy_b) vb_q <= va_q;
      if (rdy_c) vc_q <= vb_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy_a && req_valid_i) begin
      prod_q    <= prod_d;
      ic_a_q    <= req_i.intercept;
      found_a_q <= req_i.found;
    end
    if (rdy_b && va_q) begin
      rnd_q     <= rnd_d;
      ic_b_q    <= ic_a_q;
      found_b_q <= found_a_q;
    end
    if (rdy_c && vb_q) begin
      y_q   <= y_d;
      oor_q <= !found_b_q;
    end
  end

  assign out_valid_o    = vc_q;
  assign y_value_o      = y_q;
  assign out_of_range_o = oor_q;

endmodule

`default_nettype wire

FILE: rtl/piecewise_linear_eval.sv
// Top level of the piecewise linear function evaluator.
//
// Usage: the input channel carries load and evaluate transactions. A load
// (cmd 0) writes breakpoint, slope and intercept of one table entry and
// yields no result. An evaluate (cmd 1) yields one result transaction with
// y = slope * x + intercept of the segment that holds x, rounded half up
// and saturated to 32 bits, or out_of_range with y = 0 outside the span.
// num_points is set over the APB-style port at byte address 0 while idle.
// Throughput: one transaction per cycle while the receiver does not stall.
// An evaluate passes compare, segment select, multiply, round, then
// intercept add into the output register before its result is shown.
// Loads update the tables in the same stages where evaluates read them, so
// order is kept exactly. Reset empties every stage and sets num_points to
// 2; the tables are not cleared and must be loaded before use. When the
// receiver stalls, stages fill up behind the output register and
// in_ready_o drops only once the whole pipeline is full; nothing is lost or
// repeated.
`default_nettype none

module piecewise_linear_eval #(
  parameter int MAX_POINTS = pwl_pkg::MAX_POINTS_DEF,
  parameter int FRAC_BITS  = pwl_pkg::FRAC_BITS_DEF
) (
  input  wire logic                                 clk_i,
  input  wire logic                                 rst_ni,
  // input channel
  input  wire logic                                 in_valid_i,
  output logic                                      in_ready_o,
  input  wire logic                                 cmd_i,
  input  wire logic [pwl_pkg::ENTRY_W-1:0]          entry_index_i,
  input  wire logic signed [pwl_pkg::DATA_W-1:0]    x_value_i,
  input  wire logic signed [pwl_pkg::DATA_W-1:0]    slope_value_i,
  input  wire logic signed [pwl_pkg::DATA_W-1:0]    intercept_value_i,
  // result channel
  output logic                                      out_valid_o,
  input  wire logic                                 out_ready_i,
  output logic signed [pwl_pkg::DATA_W-1:0]         y_value_o,
  output logic                                      out_of_range_o,
  // configuration port
  input  wire logic                                 psel,
  input  wire logic                                 penable,
  input  wire logic                                 pwrite,
  input  wire logic [pwl_pkg::ADDR_W-1:0]           paddr,
  input  wire logic [31:0]                          pwdata,
  output logic [31:0]                               prdata,
  output logic                                      pready
);

  localparam int DW      = pwl_pkg::DATA_W;
  localparam int EW      = pwl_pkg::ENTRY_W;
  localparam int NW      = pwl_pkg::NPTS_W;
  // Only entries reachable by entry_index are ever stored.
  localparam int DEPTH   = (MAX_POINTS < (2 ** EW)) ? MAX_POINTS : (2 ** EW);
  localparam int IDX_W   = $clog2(DEPTH);

  // ---------------------------------------------------------------------
  // Configuration register
  // ---------------------------------------------------------------------
  logic [NW-1:0] num_points_q;
  logic          reg_sel;

  assign pready  = 1'b1;
  assign reg_sel = (paddr[pwl_pkg::ADDR_W-1:2] == pwl_pkg::REG_NUM_POINTS);
  assign prdata  = reg_sel ? 32'(num_points_q) : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      num_points_q <= pwl_pkg::NUM_POINTS_RST;
    end else if (psel && penable && pwrite && pready && reg_sel) begin
      num_points_q <= pwdata[NW-1:0];
    end
  end

  // ---------------------------------------------------------------------
  // Stage 1: captured transaction, breakpoint compares, breakpoint writes
  // ---------------------------------------------------------------------
  logic                 v1_q, v2_q;
  logic                 rdy1, rdy2;
  pwl_pkg::cmd_e        cmd1_q, cmd2_q;
  logic [EW-1:0]        idx1_q, idx2_q;
  logic signed [DW-1:0] x1_q, sl1_q, ic1_q;
  logic signed [DW-1:0] x2_q, sl2_q, ic2_q;
  logic [DEPTH-1:0]     hit_d, hit_q;
  logic                 idx1_ok, idx2_ok;
  logic                 mac_ready;

  logic signed [DW-1:0] bp_tab [DEPTH];
  logic signed [DW-1:0] sl_tab [DEPTH];
  logic signed [DW-1:0] ic_tab [DEPTH];

  assign rdy1       = !v1_q || rdy2;
  assign in_ready_o = rdy1;
  assign idx1_ok    = ({1'b0, idx1_q} < (EW + 1)'(DEPTH));
  assign idx2_ok    = ({1'b0, idx2_q} < (EW + 1)'(DEPTH));

  // Hit on entry i when x lies in [bp0, bp_i] and entry i is active.
  always_comb begin
    hit_d = '0;
    for (int i = 1; i < DEPTH; i++) begin
      hit_d[i] = (NW'(i) < num_points_q) && (x1_q >= bp_tab[0]) && (x1_q <= bp_tab[i]);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
    end else begin
      if (rdy1) v1_q <= in_valid_i;
      if (rdy2) v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy1 && in_valid_i) begin
      cmd1_q <= pwl_pkg::cmd_e'(cmd_i);
      idx1_q <= entry_index_i;
      x1_q   <= x_value_i;
      sl1_q  <= slope_value_i;
      ic1_q  <= intercept_value_i;
    end
    if (rdy2 && v1_q) begin
      cmd2_q <= cmd1_q;
      idx2_q <= idx1_q;
      x2_q   <= x1_q;
      sl2_q  <= sl1_q;
      ic2_q  <= ic1_q;
      hit_q  <= hit_d;
    end
  end

  // Breakpoints change where evaluates compare against them.
  always_ff @(posedge clk_i) begin
    if (v1_q && rdy2 && (cmd1_q == pwl_pkg::CMD_LOAD) && idx1_ok) begin
      bp_tab[idx1_q[IDX_W-1:0]] <= x1_q;
    end
  end

  // ---------------------------------------------------------------------
  // Stage 2: first hit picks the segment, slope/intercept writes
  // ---------------------------------------------------------------------
  logic [IDX_W-1:0]  seg;
  logic              found;
  pwl_pkg::mac_req_t mac_req;
  logic              mac_valid;

  always_comb begin
    seg   = '0;
    found = |hit_q;
    for (int i = DEPTH - 1; i >= 1; i--) begin
      if (hit_q[i]) seg = IDX_W'(i - 1);
    end
  end

  assign mac_req.slope     = sl_tab[seg];
  assign mac_req.intercept = ic_tab[seg];
  assign mac_req.x         = x2_q;
  assign mac_req.found     = found;

  // Drop loads here; only evaluates go on to the arithmetic.
  assign mac_valid = v2_q && (cmd2_q == pwl_pkg::CMD_EVAL);
  assign rdy2      = !v2_q || (cmd2_q == pwl_pkg::CMD_LOAD) || mac_ready;

  // Slopes and intercepts change where evaluates read them.
  always_ff @(posedge clk_i) begin
    if (v2_q && (cmd2_q == pwl_pkg::CMD_LOAD) && idx2_ok) begin
      sl_tab[idx2_q[IDX_W-1:0]] <= sl2_q;
      ic_tab[idx2_q[IDX_W-1:0]] <= ic2_q;
    end
  end

  // ---------------------------------------------------------------------
  // Stages 3 to 5: arithmetic and output register
  // ---------------------------------------------------------------------
  pwl_mac #(
    .FRAC_BITS (FRAC_BITS)
  ) u_mac (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .req_valid_i    (mac_valid),
    .req_ready_o    (mac_ready),
    .req_i          (mac_req),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .y_value_o      (y_value_o),
    .out_of_range_o (out_of_range_o)
  );

endmodule

`default_nettype wire

FILE: rtl/pwl_checker.sv
// Port-level assertions of the piecewise linear evaluator and their bind.
`default_nettype none

module pwl_checker (
  input wire logic                              clk_i,
  input wire logic                              rst_ni,
  input wire logic                              in_ready_o,
  input wire logic                              out_valid_o,
  input wire logic                              out_ready_i,
  input wire logic signed [pwl_pkg::DATA_W-1:0] y_value_o,
  input wire logic                              out_of_range_o,
  input wire logic                              psel,
  input wire logic                              penable,
  input wire logic                              pwrite,
  input wire logic [pwl_pkg::ADDR_W-1:0]        paddr,
  input wire logic [31:0]                       pwdata,
  input wire logic [31:0]                       prdata
);

  // Hold a stalled result.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=>
      out_valid_o && $stable(y_value_o) && $stable(out_of_range_o))
    else $error("stalled result changed");

  // Out-of-range results carry zero.
  a_oor_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_of_range_o |-> y_value_o == '0)
    else $error("out-of-range result not zero");

  // With the output register empty every stage can advance.
  a_ready_when_drained: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o |-> in_ready_o)
    else $error("input stalled with empty output");

  // Read back what was written to num_points.
  a_cfg_readback: assert property (@(posedge clk_i) disable iff (!rst_ni)
    psel && penable && pwrite && (paddr[pwl_pkg::ADDR_W-1:2] == pwl_pkg::REG_NUM_POINTS)
    |=> (paddr[pwl_pkg::ADDR_W-1:2] != pwl_pkg::REG_NUM_POINTS) ||
        (prdata == 32'($past(pwdata[pwl_pkg::NPTS_W-1:0]))))
    else $error("num_points readback mismatch");

endmodule

bind piecewise_linear_eval pwl_checker u_pwl_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .in_ready_o     (in_ready_o),
  .out_valid_o    (out_valid_o),
  .out_ready_i    (out_ready_i),
  .y_value_o      (y_value_o),
  .out_of_range_o (out_of_range_o),
  .psel           (psel),
  .penable        (penable),
  .pwrite         (pwrite),
  .paddr          (paddr),
  .pwdata         (pwdata),
  .prdata         (prdata)
);

`default_nettype wire

FILE: test/piecewise_linear_eval_tb.sv
// Self-checking testbench for the piecewise linear evaluator: table loads, evaluations, num_points.
module piecewise_linear_eval_tb;

  localparam int DATA_W      = pwl_pkg::DATA_W;
  localparam int ENTRY_W     = pwl_pkg::ENTRY_W;
  localparam int NPTS_W      = pwl_pkg::NPTS_W;
  localparam int ADDR_W      = pwl_pkg::ADDR_W;
  localparam int MAX_POINTS  = pwl_pkg::MAX_POINTS_DEF;
  localparam int FRAC_BITS   = pwl_pkg::FRAC_BITS_DEF;
  localparam int PHASE_ITEMS = 160;      // transactions per num_points setting
  localparam int DRAIN_CYCLES = 8;       // covers the five-stage pipeline plus margin
  localparam int CYCLE_LIMIT = 400000;
  localparam longint Y_MAX = 64'sd2147483647;
  localparam longint Y_MIN = -64'sd2147483648;
  localparam logic [ADDR_W-1:0] NPTS_ADDR  = ADDR_W'(4 * pwl_pkg::REG_NUM_POINTS);
  // First address past the only register; writes there must be dropped.
  localparam logic [ADDR_W-1:0] SPARE_ADDR = ADDR_W'(4 * (pwl_pkg::REG_NUM_POINTS + 1));

  typedef struct {
    pwl_pkg::cmd_e            cmd;
    logic [ENTRY_W-1:0]       idx;
    logic signed [DATA_W-1:0] x;
    logic signed [DATA_W-1:0] slope;
    logic signed [DATA_W-1:0] icpt;
  } pwl_item_t;

  typedef struct {
    logic signed [DATA_W-1:0] y;
    logic                     oor;
  } pwl_result_t;

  typedef enum logic [1:0] {
    RDY_ALWAYS,
    RDY_COIN,
    RDY_SPARSE,
    RDY_MOSTLY
  } ready_mode_e;

  // Clock, reset and every block input start at known values.
  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_ready_o;
  logic cmd_i = 1'b0;
  logic [ENTRY_W-1:0] entry_index_i = '0;
  logic signed [DATA_W-1:0] x_value_i = '0;
  logic signed [DATA_W-1:0] slope_value_i = '0;
  logic signed [DATA_W-1:0] intercept_value_i = '0;
  logic out_valid_o;
  logic out_ready_i = 1'b0;
  logic signed [DATA_W-1:0] y_value_o;
  logic out_of_range_o;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [ADDR_W-1:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;

  // Shadow copy of the block's tables and register, updated in acceptance order.
  logic signed [DATA_W-1:0] shadow_bp    [MAX_POINTS];
  logic signed [DATA_W-1:0] shadow_slope [MAX_POINTS];
  logic signed [DATA_W-1:0] shadow_icpt  [MAX_POINTS];
  logic [NPTS_W-1:0]        shadow_npts = pwl_pkg::NUM_POINTS_RST;

  // Breakpoints as the stimulus generator last queued them, used to aim arguments.
  int gen_bp [MAX_POINTS];

  pwl_item_t   queued_cmds [$];
  pwl_result_t predicted_y [$];

  int unsigned items_queued = 0;
  int unsigned items_accepted = 0;
  int unsigned mismatch_count = 0;
  int unsigned load_count = 0;
  int unsigned eval_count = 0;
  int unsigned oor_count = 0;
  int unsigned sat_count = 0;
  int unsigned setting_count = 0;
  int unsigned cycle_count = 0;
  int unsigned burst_left = 0;
  int unsigned gap_left = 0;
  int unsigned mode_left = 0;
  ready_mode_e rdy_mode = RDY_ALWAYS;

  piecewise_linear_eval DUT (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .in_valid_i        (in_valid_i),
    .in_ready_o        (in_ready_o),
    .cmd_i             (cmd_i),
    .entry_index_i     (entry_index_i),
    .x_value_i         (x_value_i),
    .slope_value_i     (slope_value_i),
    .intercept_value_i (intercept_value_i),
    .out_valid_o       (out_valid_o),
    .out_ready_i       (out_ready_i),
    .y_value_o         (y_value_o),
    .out_of_range_o    (out_of_range_o),
    .psel              (psel),
    .penable           (penable),
    .pwrite            (pwrite),
    .paddr             (paddr),
    .pwdata            (pwdata),
    .prdata            (prdata),
    .pready            (pready)
  );

  always #5 clk_i = ~clk_i;

  // Hard stop in case the block hangs.
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("simulation failed");
      $finish;
    end
  end

  task automatic note_mismatch(input string what, input logic [31:0] want,
                               input logic [31:0] got);
    mismatch_count++;
    if (mismatch_count <= 10)
      $display("MISMATCH %s: expected %h, got %h (cycle %0d)", what, want, got, cycle_count);
  endtask

  // Apply one accepted transaction to the shadow tables; evaluations queue their
  // expected y and range flag.
  task automatic compute_pwl_output(input pwl_item_t it);
    int unsigned len;
    int unsigned seg;
    bit hit;
    longint prod;
    longint y;
    pwl_result_t r;
    if (it.cmd == pwl_pkg::CMD_LOAD) begin
      // Index is 4 bits, so every load lands inside the table.
      shadow_bp[it.idx]    = it.x;
      shadow_slope[it.idx] = it.slope;
      shadow_icpt[it.idx]  = it.icpt;
      load_count++;
      return;
    end
    eval_count++;
    // Counts past the table size clamp to the table size.
    len = (shadow_npts > MAX_POINTS) ? MAX_POINTS : shadow_npts;
    hit = 1'b0;
    seg = 0;
    // First breakpoint from the second on that is at or above x closes the segment.
    if (len >= 2 && it.x >= shadow_bp[0]) begin
      for (int unsigned i = 1; i < len; i++) begin
        if (!hit && it.x <= shadow_bp[i]) begin
          seg = i - 1;
          hit = 1'b1;
        end
      end
    end
    if (hit) begin
      prod = longint'(shadow_slope[seg]) * longint'(it.x);
      // Round half up, then floor shift back to Q16.16.
      y = ((prod + (longint'(1) << (FRAC_BITS - 1))) >>> FRAC_BITS)
          + longint'(shadow_icpt[seg]);
      if (y > Y_MAX || y < Y_MIN) sat_count++;
      if (y > Y_MAX) y = Y_MAX;
      if (y < Y_MIN) y = Y_MIN;
      r.y   = y[DATA_W-1:0];
      r.oor = 1'b0;
    end else begin
      r.y   = '0;
      r.oor = 1'b1;
      oor_count++;
    end
    predicted_y.push_back(r);
  endtask

  // Driver: present queued transactions in bursts separated by random gaps.
  always @(posedge clk_i) begin : drive_inputs
    pwl_item_t nxt;
    logic present;
    static pwl_item_t cur;
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else begin
      if (in_valid_i && in_ready_o) begin
        compute_pwl_output(cur);
        items_accepted++;
      end
      if (!in_valid_i || in_ready_o) begin
        present = 1'b0;
        if (gap_left > 0) begin
          gap_left--;
        end else if (queued_cmds.size() > 0) begin
          nxt = queued_cmds.pop_front();
          present = 1'b1;
          if (burst_left > 0) burst_left--;
          // Pick the next burst; some are long and back to back to keep the pipe full.
          if (burst_left == 0) begin
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(64, 256)
                                                    : $urandom_range(1, 24);
            gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
          end
        end
        if (present) begin
          cur = nxt;
          cmd_i             <= nxt.cmd;
          entry_index_i     <= nxt.idx;
          x_value_i         <= nxt.x;
          slope_value_i     <= nxt.slope;
          intercept_value_i <= nxt.icpt;
        end
        in_valid_i <= present;
      end
    end
  end

  // Monitor: check each result transaction against the oldest prediction and
  // throttle out_ready_i through a changing stall mode.
  always @(posedge clk_i) begin : check_outputs
    pwl_result_t want;
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
    end else begin
      if (out_valid_o && out_ready_i) begin
        if (predicted_y.size() == 0) begin
          note_mismatch("result with nothing pending", '0, y_value_o);
        end else begin
          want = predicted_y.pop_front();
          if (y_value_o !== want.y) note_mismatch("y_value", want.y, y_value_o);
          if (out_of_range_o !== want.oor)
            note_mismatch("out_of_range", 32'(want.oor), 32'(out_of_range_o));
        end
      end
      if (mode_left == 0) begin
        rdy_mode  = ready_mode_e'($urandom_range(0, 3));
        mode_left = $urandom_range(32, 256);
      end else begin
        mode_left--;
      end
      case (rdy_mode)
        RDY_ALWAYS: out_ready_i <= 1'b1;
        RDY_COIN:   out_ready_i <= 1'($urandom_range(0, 1));
        RDY_SPARSE: out_ready_i <= (cycle_count % 4 == 0);
        default:    out_ready_i <= ($urandom_range(0, 9) != 0);
      endcase
    end
  end

  // Register write: setup cycle, then access until pready.
  task automatic apb_write(input logic [ADDR_W-1:0] a, input logic [31:0] d);
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= a;
    pwdata  <= d;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    if (a == NPTS_ADDR) begin
      shadow_npts = d[NPTS_W-1:0];
      setting_count++;
    end
  endtask

  // Read num_points back and compare with the shadow copy.
  task automatic check_num_points();
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= NPTS_ADDR;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    if (prdata !== 32'(shadow_npts)) note_mismatch("num_points readback", 32'(shadow_npts), prdata);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // Hold until every queued transaction was taken and every result came back,
  // then let in-flight loads retire.
  task automatic wait_idle();
    while (items_accepted != items_queued || predicted_y.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic push_cmd(input pwl_pkg::cmd_e c, input logic [ENTRY_W-1:0] idx,
                          input logic signed [DATA_W-1:0] x,
                          input logic signed [DATA_W-1:0] s,
                          input logic signed [DATA_W-1:0] ic);
    pwl_item_t it;
    it.cmd   = c;
    it.idx   = idx;
    it.x     = x;
    it.slope = s;
    it.icpt  = ic;
    queued_cmds.push_back(it);
    items_queued++;
    if (c == pwl_pkg::CMD_LOAD) gen_bp[idx] = x;
  endtask

  // Mostly modest Q16.16 values when narrow is set, with full-range words and the extremes mixed in.
  function automatic logic signed [DATA_W-1:0] pick_word(input bit narrow);
    case ($urandom_range(0, 19))
      0:       return 32'sh8000_0000;
      1:       return 32'sh7FFF_FFFF;
      2:       return '0;
      3:       return '1;
      4, 5, 6: return $urandom;
      default: return narrow ? (int'($urandom_range(0, 32'h0020_0000)) - 32'sh0010_0000)
                             : $urandom;
    endcase
  endfunction

  // Load entries 0..n-1 with ascending breakpoints and random segments.
  task automatic load_sorted_table(input int unsigned n, input bit narrow);
    int pts[$];
    repeat (n) pts.push_back(pick_word(narrow));
    pts.sort();
    foreach (pts[k])
      push_cmd(pwl_pkg::CMD_LOAD, ENTRY_W'(k), pts[k], pick_word(1'b1), pick_word(1'b1));
  endtask

  // Evaluate at an argument aimed at a segment, a breakpoint or just past the span.
  task automatic push_aimed_eval(input int unsigned n);
    int unsigned k;
    longint lo;
    longint hi;
    longint x;
    longint unsigned r64;
    longint unsigned span;
    k  = $urandom_range(0, n - 2);
    lo = gen_bp[k];
    hi = gen_bp[k + 1];
    r64 = {$urandom, $urandom};
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4: begin
        span = hi - lo + 1;
        x = (hi > lo) ? lo + longint'(r64 % span) : hi;
      end
      5:       x = gen_bp[$urandom_range(0, n - 1)];
      6:       x = longint'(gen_bp[0]) - 1 - longint'($urandom_range(0, 255));
      7:       x = longint'(gen_bp[n - 1]) + 1 + longint'($urandom_range(0, 255));
      8:       x = longint'($urandom_range(0, 2)) - 1;
      default: x = hi;
    endcase
    if (x > Y_MAX) x = Y_MAX;
    if (x < Y_MIN) x = Y_MIN;
    // Unused fields of an evaluate carry random bits.
    push_cmd(pwl_pkg::CMD_EVAL, ENTRY_W'($urandom), x[DATA_W-1:0], $urandom, $urandom);
  endtask

  // One num_points setting: write it, read it back, load a table and exercise it.
  task automatic run_phase(input logic [NPTS_W-1:0] npts, input bit poke_spare);
    logic [31:0] wdata;
    int unsigned tn;
    int unsigned start;
    int unsigned k;
    if (poke_spare) apb_write(SPARE_ADDR, $urandom);
    wdata = $urandom;
    wdata[NPTS_W-1:0] = npts;
    apb_write(NPTS_ADDR, wdata);
    check_num_points();
    // With fewer than two points nothing is in range; still load a real table.
    tn = (npts < 2) ? $urandom_range(2, MAX_POINTS) : ((npts > MAX_POINTS) ? MAX_POINTS : npts);
    start = items_queued;
    load_sorted_table(tn, $urandom_range(0, 1));
    while (items_queued - start < PHASE_ITEMS) begin
      k = $urandom_range(0, 99);
      if (k < 60) begin
        push_aimed_eval(tn);
      end else if (k < 68) begin
        load_sorted_table(tn, $urandom_range(0, 1));
      end else if (k < 78) begin
        // Replace one segment but keep its breakpoint so the order holds.
        k = $urandom_range(0, tn - 1);
        push_cmd(pwl_pkg::CMD_LOAD, ENTRY_W'(k), gen_bp[k], pick_word(1'b1),
                 pick_word(1'b1));
      end else if (k < 88) begin
        // Noise load: anywhere, any breakpoint, may break the ascending order.
        push_cmd(pwl_pkg::CMD_LOAD, ENTRY_W'($urandom), pick_word($urandom_range(0, 1)),
                 $urandom, $urandom);
      end else begin
        push_cmd(pwl_pkg::CMD_EVAL, ENTRY_W'($urandom), $urandom, $urandom, $urandom);
      end
    end
    wait_idle();
  endtask

  initial begin
    logic [NPTS_W-1:0] npts;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Reset value of num_points must read back as two.
    check_num_points();

    // Directed: fill all sixteen entries so no evaluate ever reads an unwritten one.
    // Entry 0 carries the most negative slope and the largest intercept.
    push_cmd(pwl_pkg::CMD_LOAD, 0, 32'shFFFF_0000, 32'sh8000_0000, 32'sh7FFF_FFFF);
    push_cmd(pwl_pkg::CMD_LOAD, 1, 32'sh7FFF_0000, 32'sh0001_0000, 32'sh8000_0000);
    for (int e = 2; e < MAX_POINTS; e++)
      push_cmd(pwl_pkg::CMD_LOAD, ENTRY_W'(e), 32'sh7FFF_FFF0 + e,
               (e % 2) ? -(e <<< 16) : (e <<< 16), -e);
    push_cmd(pwl_pkg::CMD_EVAL, 0, 32'sh8000_0000, '0, '0);  // far below the first breakpoint
    push_cmd(pwl_pkg::CMD_EVAL, 0, 32'shFFFE_0000, '0, '0);  // just below
    push_cmd(pwl_pkg::CMD_EVAL, 0, 32'shFFFF_0000, '0, '0);  // on the first breakpoint, saturates high
    push_cmd(pwl_pkg::CMD_EVAL, 0, 32'sh0000_0000, '0, '0);  // intercept only
    push_cmd(pwl_pkg::CMD_EVAL, 0, 32'sh0000_0001, '0, '0);  // rounding of a tiny product
    push_cmd(pwl_pkg::CMD_EVAL, 0, 32'sh7FFF_0000, '0, '0);  // on the last breakpoint, saturates low
    push_cmd(pwl_pkg::CMD_EVAL, 0, 32'sh7FFF_0001, '0, '0);  // just above the span
    push_cmd(pwl_pkg::CMD_EVAL, 0, 32'sh7FFF_FFFF, '0, '0);  // far above
    wait_idle();

    // Random part: extremes, out-of-bounds counts and in-between settings.
    for (int p = 0; p < 12; p++) begin
      case (p)
        0:       npts = 16;
        1:       npts = 3;
        2:       npts = 0;
        3:       npts = 9;
        4:       npts = 1;
        5:       npts = 31;
        6:       npts = 17;
        7:       npts = 2;
        8:       npts = 16;
        9:       npts = 12;
        10:      npts = NPTS_W'($urandom_range(2, MAX_POINTS));
        default: npts = NPTS_W'($urandom_range(0, 31));
      endcase
      run_phase(npts, (p % 3) == 0);
    end

    $display("ran %0d table loads and %0d evaluations over %0d num_points writes",
             load_count, eval_count, setting_count);
    $display("%0d evaluations out of range, %0d saturated, %0d mismatches",
             oor_count, sat_count, mismatch_count);
    if (mismatch_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
